[sv/crk_pkg.sv]
// ----------------------------------------------------------------------------
// crk_pkg
// shared types, codes and the rk4 microprogram of the chua integrator
// ----------------------------------------------------------------------------
package crk_pkg;

  localparam int DW = 48;

  typedef logic signed [DW-1:0] fx_t;

  localparam fx_t FX_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam fx_t FX_ONE = 48'sh0001_0000_0000;

  // operation codes
  typedef logic [2:0] op_t;
  localparam op_t OP_ADD   = 3'd0;
  localparam op_t OP_SUB   = 3'd1;
  localparam op_t OP_ABS   = 3'd2;
  localparam op_t OP_MUL   = 3'd3;  // product >> 32
  localparam op_t OP_MULH  = 3'd4;  // product >> 33
  localparam op_t OP_MULD6 = 3'd5;  // product >> 32, then / 6

  // operand a sources
  typedef logic [1:0] asel_t;
  localparam asel_t AS_REG  = 2'd0;
  localparam asel_t AS_ZERO = 2'd1;
  localparam asel_t AS_M0   = 2'd2;

  // operand b sources
  typedef logic [2:0] bsel_t;
  localparam bsel_t BS_REG  = 3'd0;
  localparam bsel_t BS_ZERO = 3'd1;
  localparam bsel_t BS_DT   = 3'd2;
  localparam bsel_t BS_CA   = 3'd3;
  localparam bsel_t BS_CB   = 3'd4;
  localparam bsel_t BS_M1   = 3'd5;
  localparam bsel_t BS_ONE  = 3'd6;

  // write data sources
  typedef logic [1:0] wsrc_t;
  localparam wsrc_t WS_ALU  = 2'd0;
  localparam wsrc_t WS_MUL  = 2'd1;
  localparam wsrc_t WS_INIT = 2'd2;

  // multiplier modes
  typedef logic [1:0] mmode_t;
  localparam mmode_t MM_SH32 = 2'd0;
  localparam mmode_t MM_SH33 = 2'd1;
  localparam mmode_t MM_D6   = 2'd2;

  // register file map
  typedef logic [3:0] raddr_t;
  localparam raddr_t R_X  = 4'd0;
  localparam raddr_t R_Y  = 4'd1;
  localparam raddr_t R_Z  = 4'd2;
  localparam raddr_t R_TX = 4'd3;
  localparam raddr_t R_TY = 4'd4;
  localparam raddr_t R_TZ = 4'd5;
  localparam raddr_t R_SX = 4'd6;
  localparam raddr_t R_DM = 4'd9;
  localparam raddr_t R_P  = 4'd10;
  localparam raddr_t R_T  = 4'd11;
  localparam raddr_t R_G  = 4'd12;
  localparam raddr_t R_K0 = 4'd13;
  localparam raddr_t R_K1 = 4'd14;
  localparam raddr_t R_K2 = 4'd15;

  localparam logic [4:0] PC_LAST    = 5'd30;
  localparam logic [4:0] PC_ACC     = 5'd19;
  localparam logic [1:0] STAGE_LAST = 2'd3;
  localparam logic [1:0] LOAD_LAST  = 2'd2;

  typedef struct packed {
    op_t    op;
    asel_t  asel;
    bsel_t  bsel;
    raddr_t wa;
    raddr_t ra;
    raddr_t rb;
  } instr_t;

  typedef struct packed {
    instr_t     ins;
    logic       rf_we;
    wsrc_t      wsrc;
    logic [1:0] ld_idx;
    logic       cap_init;
    logic       mstart;
    logic       emit;
  } cmd_t;

  // one rk stage: derivative, accumulation of k, then the next stage input or, on the last stage, the new state
  function automatic instr_t crk_instr(input logic [4:0] pc, input logic [1:0] st);
    instr_t     i;
    logic [4:0] j;
    raddr_t     c;
    logic       first;
    logic       last;
    i.op   = OP_ADD;
    i.asel = AS_REG;
    i.bsel = BS_ZERO;
    i.wa   = R_T;
    i.ra   = R_T;
    i.rb   = R_T;
    j      = pc - PC_ACC;
    c      = {2'b00, j[3:2]};
    first  = (st == 2'd0);
    last   = (st == STAGE_LAST);
    case (pc)
      5'd0: begin
        i.op = OP_SUB; i.asel = AS_M0; i.bsel = BS_M1; i.wa = R_DM;
      end
      // copy state into stage inputs on the first stage only
      5'd1: begin i.ra = R_X; i.wa = first ? R_TX : R_T; end
      5'd2: begin i.ra = R_Y; i.wa = first ? R_TY : R_T; end
      5'd3: begin i.ra = R_Z; i.wa = first ? R_TZ : R_T; end
      5'd4: begin i.ra = R_TX; i.bsel = BS_ONE; i.wa = R_T; end
      5'd5: begin i.op = OP_ABS; i.ra = R_T; i.wa = R_T; end
      5'd6: begin i.op = OP_SUB; i.ra = R_TX; i.bsel = BS_ONE; i.wa = R_P; end
      5'd7: begin i.op = OP_ABS; i.ra = R_P; i.wa = R_P; end
      5'd8: begin i.op = OP_SUB; i.ra = R_T; i.rb = R_P; i.bsel = BS_REG; i.wa = R_P; end
      5'd9: begin i.op = OP_MUL; i.ra = R_TX; i.bsel = BS_M1; i.wa = R_G; end
      5'd10: begin i.op = OP_MUL; i.ra = R_DM; i.rb = R_P; i.bsel = BS_REG; i.wa = R_T; end
      5'd11: begin i.ra = R_G; i.rb = R_T; i.bsel = BS_REG; i.wa = R_G; end
      5'd12: begin i.op = OP_SUB; i.ra = R_TY; i.rb = R_TX; i.bsel = BS_REG; i.wa = R_T; end
      5'd13: begin i.op = OP_SUB; i.ra = R_T; i.rb = R_G; i.bsel = BS_REG; i.wa = R_T; end
      5'd14: begin i.op = OP_MUL; i.ra = R_T; i.bsel = BS_CA; i.wa = R_K0; end
      5'd15: begin i.op = OP_SUB; i.ra = R_TX; i.rb = R_TY; i.bsel = BS_REG; i.wa = R_T; end
      5'd16: begin i.ra = R_T; i.rb = R_TZ; i.bsel = BS_REG; i.wa = R_K1; end
      5'd17: begin i.op = OP_MUL; i.ra = R_TY; i.bsel = BS_CB; i.wa = R_T; end
      5'd18: begin
        i.op = OP_SUB; i.asel = AS_ZERO; i.rb = R_T; i.bsel = BS_REG; i.wa = R_K2;
      end
      default: begin
        case (j[1:0])
          2'd0: begin
            if (first) begin
              i.ra = R_K0 + c; i.wa = R_SX + c;
            end else if (last) begin
              i.ra = R_SX + c; i.rb = R_K0 + c; i.bsel = BS_REG; i.wa = R_SX + c;
            end else begin
              i.ra = R_K0 + c; i.rb = R_K0 + c; i.bsel = BS_REG; i.wa = R_T;
            end
          end
          2'd1: begin
            i.ra = R_SX + c; i.wa = R_SX + c;
            if (!first && !last) begin
              i.rb = R_T; i.bsel = BS_REG;
            end
          end
          2'd2: begin
            i.bsel = BS_DT; i.wa = R_T;
            if (last) begin
              i.op = OP_MULD6; i.ra = R_SX + c;
            end else begin
              i.op = (st == STAGE_LAST - 2'd1) ? OP_MUL : OP_MULH; i.ra = R_K0 + c;
            end
          end
          default: begin
            i.ra = R_X + c; i.rb = R_T; i.bsel = BS_REG;
            i.wa = last ? R_X + c : R_TX + c;
          end
        endcase
      end
    endcase
    return i;
  endfunction

endpackage

[sv/chua_rk4_integrator.sv]
// ----------------------------------------------------------------------------
// chua_rk4_integrator
// chua circuit integrated by fixed-step rk4 in saturating q16.32
// ----------------------------------------------------------------------------
// load item: x, y and z are written in turn, then the next item is taken
// advance item: paced by one shared multiplier (accumulate and post states, plus
//   divide states for the divide by six) and a register read state ahead of each
//   of the 124 microprogram steps
// a result waiting on out_ready holds only the following emitting step
// synchronous active-low reset: state, step count zero; dt 429497, decim 100
module chua_rk4_integrator import crk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  fx_t         in_init_x,
  input  fx_t         in_init_y,
  input  fx_t         in_init_z,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output fx_t         out_x,
  output fx_t         out_y,
  output fx_t         out_z,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // register indexes, 8 bytes apart
  localparam logic [2:0] CFG_A     = 3'd0;
  localparam logic [2:0] CFG_B     = 3'd1;
  localparam logic [2:0] CFG_M0    = 3'd2;
  localparam logic [2:0] CFG_M1    = 3'd3;
  localparam logic [2:0] CFG_DT    = 3'd4;
  localparam logic [2:0] CFG_DECIM = 3'd5;

  localparam logic [31:0] DT_RST    = 32'd429497;
  localparam logic [15:0] DECIM_RST = 16'd100;

  fx_t         coef_a_r, coef_b_r, m0_r, m1_r;
  logic [31:0] dt_r;
  logic [15:0] decim_r;
  logic [2:0]  cidx;
  logic        cfg_wr;
  cmd_t        cmd;
  logic        mul_done;

  assign cidx   = paddr[5:3];
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes, indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= '0;
      coef_b_r <= '0;
      m0_r     <= '0;
      m1_r     <= '0;
      dt_r     <= DT_RST;
      decim_r  <= DECIM_RST;
    end else if (cfg_wr) begin
      case (cidx)
        CFG_A:     coef_a_r <= pwdata[DW-1:0];
        CFG_B:     coef_b_r <= pwdata[DW-1:0];
        CFG_M0:    m0_r     <= pwdata[DW-1:0];
        CFG_M1:    m1_r     <= pwdata[DW-1:0];
        CFG_DT:    dt_r     <= pwdata[31:0];
        CFG_DECIM: decim_r  <= pwdata[15:0];
        default:   decim_r  <= decim_r;
      endcase
    end
  end

  // readback, signed registers sign-extended
  always_comb begin
    case (cidx)
      CFG_A:     prdata = {{16{coef_a_r[DW-1]}}, coef_a_r};
      CFG_B:     prdata = {{16{coef_b_r[DW-1]}}, coef_b_r};
      CFG_M0:    prdata = {{16{m0_r[DW-1]}}, m0_r};
      CFG_M1:    prdata = {{16{m1_r[DW-1]}}, m1_r};
      CFG_DT:    prdata = {32'd0, dt_r};
      CFG_DECIM: prdata = {48'd0, decim_r};
      default:   prdata = '0;
    endcase
  end

  // sequencer: microprogram counter, stage, step count, handshakes
  crk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .decim     (decim_r),
    .mul_done  (mul_done),
    .cmd       (cmd)
  );

  // register file, saturating alu and multiplier
  crk_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .coef_a      (coef_a_r),
    .coef_b      (coef_b_r),
    .slope_inner (m0_r),
    .slope_outer (m1_r),
    .step_size   (dt_r),
    .init_x      (in_init_x),
    .init_y      (in_init_y),
    .init_z      (in_init_z),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .mul_done    (mul_done)
  );

  // an accepted item always keeps the block busy for the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one still in work");

  // a new result only appears at the end of a step, never from idle
  a_emit_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a step in work");

  // multiplier completes only while the sequencer is mid-step
  a_mul_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> !in_ready)
    else $error("multiplier finished while idle");

endmodule

[sv/crk_mul.sv]
// ----------------------------------------------------------------------------
// crk_mul
// multi-cycle 48x48 fixed-point multiplier with shift, saturation and a
// radix-256 divide by three for the final rk4 sum
// ----------------------------------------------------------------------------
module crk_mul import crk_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  mmode_t mode,
  input  fx_t    a,
  input  fx_t    b,
  output fx_t    res,
  output logic   done
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_ACC  = 2'd1;
  localparam logic [1:0] M_POST = 2'd2;
  localparam logic [1:0] M_DIV  = 2'd3;

  localparam logic [2:0]  ACC_LAST   = 3'd2;
  localparam logic [2:0]  DIV_LAST   = 3'd5;
  localparam logic [47:0] DIV_BIAS   = 48'hC000_0000_0000;
  localparam logic [47:0] DIV_OFFSET = 48'h4000_0000_0000;

  logic [1:0]          mst_r, mst_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  mmode_t              mode_r, mode_nxt;
  fx_t                 a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic signed [95:0]  acc_r, acc_nxt;
  logic [47:0]         div_r, div_nxt;
  logic [1:0]          rem_r, rem_nxt;
  logic                done_r, done_nxt;

  logic signed [16:0]  dig;
  logic signed [64:0]  pp;
  logic signed [95:0]  ppx, shv;
  logic [47:0]         uval;
  logic [2:0]          r3;
  logic [1:0]          rr;
  logic [47:0]         q;

  always_comb begin
    mst_nxt  = mst_r;
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;

    case (cnt_r)
      3'd0:    dig = {1'b0, b_r[15:0]};
      3'd1:    dig = {1'b0, b_r[31:16]};
      default: dig = {b_r[47], b_r[47:32]};
    endcase
    pp  = a_r * dig;
    ppx = {{31{pp[64]}}, pp};
    case (cnt_r)
      3'd0:    ppx = ppx;
      3'd1:    ppx = ppx <<< 16;
      default: ppx = ppx <<< 32;
    endcase

    shv  = (mode_r == MM_SH33) ? (acc_r >>> 33) : (acc_r >>> 32);
    uval = {shv[47], shv[47:1]};

    // eight restoring steps of the divide by three
    rr = rem_r;
    q  = div_r;
    for (int k = 0; k < 8; k++) begin
      r3 = {rr, q[47]};
      q  = {q[46:0], 1'b0};
      if (r3 >= 3'd3) begin
        r3   = r3 - 3'd3;
        q[0] = 1'b1;
      end
      rr = r3[1:0];
    end

    case (mst_r)
      M_IDLE: begin
        if (start) begin
          a_nxt    = a;
          b_nxt    = b;
          mode_nxt = mode;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          mst_nxt  = M_ACC;
        end
      end
      M_ACC: begin
        acc_nxt = acc_r + ppx;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == ACC_LAST) begin
          mst_nxt = M_POST;
        end
      end
      M_POST: begin
        if (mode_r == MM_D6) begin
          // bias keeps the dividend positive so the quotient floors
          div_nxt = uval + DIV_BIAS;
          rem_nxt = '0;
          cnt_nxt = '0;
          mst_nxt = M_DIV;
        end else begin
          if (shv[95:47] == {49{shv[47]}}) begin
            res_nxt = shv[47:0];
          end else begin
            res_nxt = acc_r[95] ? FX_MIN : FX_MAX;
          end
          done_nxt = 1'b1;
          mst_nxt  = M_IDLE;
        end
      end
      default: begin
        div_nxt = q;
        rem_nxt = rr;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == DIV_LAST) begin
          res_nxt  = q - DIV_OFFSET;
          done_nxt = 1'b1;
          mst_nxt  = M_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mst_r  <= M_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      mst_r  <= mst_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
  end

  assign res  = res_r;
  assign done = done_r;

endmodule

[sv/crk_dp.sv]
// ----------------------------------------------------------------------------
// crk_dp
// datapath: register file, state registers, saturating alu, multiplier
// ----------------------------------------------------------------------------
module crk_dp import crk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  fx_t         coef_a,
  input  fx_t         coef_b,
  input  fx_t         slope_inner,
  input  fx_t         slope_outer,
  input  logic [31:0] step_size,
  input  fx_t         init_x,
  input  fx_t         init_y,
  input  fx_t         init_z,
  output fx_t         out_x,
  output fx_t         out_y,
  output fx_t         out_z,
  output logic        mul_done
);

  function automatic fx_t sat_add(input fx_t a, input fx_t b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? FX_MIN : FX_MAX;
    return s[DW-1:0];
  endfunction

  function automatic fx_t sat_sub(input fx_t a, input fx_t b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? FX_MIN : FX_MAX;
    return s[DW-1:0];
  endfunction

  fx_t rf_mem [16];
  fx_t rd_a_r, rd_b_r;
  fx_t sx_r, sy_r, sz_r, sx_nxt, sy_nxt, sz_nxt;
  fx_t ix_r, iy_r, iz_r;
  fx_t ox_r, oy_r, oz_r;
  fx_t a_op, b_op, alu_res, mul_res, wdata, sel_a;
  mmode_t mmode;

  // state lives in flops so that it reads as zero after reset
  always_comb begin
    case (cmd.ins.ra)
      R_X:     sel_a = sx_r;
      R_Y:     sel_a = sy_r;
      R_Z:     sel_a = sz_r;
      default: sel_a = rf_mem[cmd.ins.ra];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rf_we) begin
      rf_mem[cmd.ins.wa] <= wdata;
    end
    rd_a_r <= sel_a;
    rd_b_r <= rf_mem[cmd.ins.rb];
  end

  always_comb begin
    case (cmd.ins.asel)
      AS_ZERO: a_op = '0;
      AS_M0:   a_op = slope_inner;
      default: a_op = rd_a_r;
    endcase
    case (cmd.ins.bsel)
      BS_ZERO: b_op = '0;
      BS_DT:   b_op = {16'd0, step_size};
      BS_CA:   b_op = coef_a;
      BS_CB:   b_op = coef_b;
      BS_M1:   b_op = slope_outer;
      BS_ONE:  b_op = FX_ONE;
      default: b_op = rd_b_r;
    endcase
    case (cmd.ins.op)
      OP_SUB:  alu_res = sat_sub(a_op, b_op);
      OP_ABS:  alu_res = a_op[DW-1] ? sat_sub('0, a_op) : a_op;
      default: alu_res = sat_add(a_op, b_op);
    endcase
    case (cmd.ins.op)
      OP_MULH:  mmode = MM_SH33;
      OP_MULD6: mmode = MM_D6;
      default:  mmode = MM_SH32;
    endcase
    case (cmd.wsrc)
      WS_MUL: wdata = mul_res;
      WS_INIT: begin
        case (cmd.ld_idx)
          2'd0:    wdata = ix_r;
          2'd1:    wdata = iy_r;
          default: wdata = iz_r;
        endcase
      end
      default: wdata = alu_res;
    endcase
  end

  // state with the write of this cycle applied, for the output capture
  always_comb begin
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    sz_nxt = sz_r;
    if (cmd.rf_we) begin
      case (cmd.ins.wa)
        R_X:     sx_nxt = wdata;
        R_Y:     sy_nxt = wdata;
        R_Z:     sz_nxt = wdata;
        default: sx_nxt = sx_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      sz_r <= '0;
    end else begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      sz_r <= sz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_init) begin
      ix_r <= init_x;
      iy_r <= init_y;
      iz_r <= init_z;
    end
    if (cmd.emit) begin
      ox_r <= sx_nxt;
      oy_r <= sy_nxt;
      oz_r <= sz_nxt;
    end
  end

  crk_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mstart),
    .mode  (mmode),
    .a     (a_op),
    .b     (b_op),
    .res   (mul_res),
    .done  (mul_done)
  );

  assign out_x = ox_r;
  assign out_y = oy_r;
  assign out_z = oz_r;

endmodule

[sv/crk_ctrl.sv]
// ----------------------------------------------------------------------------
// crk_ctrl
// sequencer: walks the rk4 microprogram, counts steps, owns the handshakes
// ----------------------------------------------------------------------------
module crk_ctrl import crk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] decim,
  input  logic        mul_done,
  output cmd_t        cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MWAIT = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  pc_r, pc_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [1:0]  ld_r, ld_nxt;
  logic [15:0] scnt_r, scnt_nxt, scnt_inc;
  logic        ov_r, ov_nxt;
  instr_t      ins;
  logic        is_mul, adv, emit;

  assign ins      = crk_instr(pc_r, st_r);
  assign is_mul   = (ins.op == OP_MUL) || (ins.op == OP_MULH) || (ins.op == OP_MULD6);
  assign scnt_inc = scnt_r + 16'd1;

  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    st_nxt     = st_r;
    ld_nxt     = ld_r;
    scnt_nxt   = scnt_r;
    adv        = 1'b0;
    emit       = 1'b0;
    cmd        = '0;
    cmd.ins    = ins;
    cmd.ld_idx = ld_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func) begin
            pc_nxt    = '0;
            st_nxt    = '0;
            state_nxt = S_READ;
          end else begin
            cmd.cap_init = 1'b1;
            scnt_nxt     = '0;
            ld_nxt       = '0;
            state_nxt    = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.rf_we  = 1'b1;
        cmd.wsrc   = WS_INIT;
        cmd.ins.wa = R_X + {2'b00, ld_r};
        ld_nxt     = ld_r + 2'd1;
        if (ld_r == LOAD_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (is_mul) begin
          cmd.mstart = 1'b1;
          state_nxt  = S_MWAIT;
        end else begin
          cmd.rf_we = 1'b1;
          cmd.wsrc  = WS_ALU;
          adv       = 1'b1;
        end
      end
      S_MWAIT: begin
        if (mul_done) begin
          cmd.rf_we = 1'b1;
          cmd.wsrc  = WS_MUL;
          adv       = 1'b1;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (adv) begin
      if (pc_r == PC_LAST) begin
        pc_nxt = '0;
        if (st_r == STAGE_LAST) begin
          if (scnt_inc >= decim) begin
            scnt_nxt = '0;
            if (ov_r && !out_ready) begin
              state_nxt = S_OUT;
            end else begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            scnt_nxt  = scnt_inc;
            state_nxt = S_IDLE;
          end
        end else begin
          st_nxt    = st_r + 2'd1;
          state_nxt = S_READ;
        end
      end else begin
        pc_nxt    = pc_r + 5'd1;
        state_nxt = S_READ;
      end
    end

    cmd.emit = emit;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      st_r    <= '0;
      ld_r    <= '0;
      scnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      st_r    <= st_nxt;
      ld_r    <= ld_nxt;
      scnt_r  <= scnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

endmodule

[sim/crk_tb_pkg.sv]
// ----------------------------------------------------------------------------
// crk_tb_pkg
// register indexes and item codes shared by the chua integrator testbench
// ----------------------------------------------------------------------------
package crk_tb_pkg;

  // register indexes, each register at byte address 8*index
  localparam int REG_COEF_A      = 0;
  localparam int REG_COEF_B      = 1;
  localparam int REG_SLOPE_INNER = 2;
  localparam int REG_SLOPE_OUTER = 3;
  localparam int REG_STEP_SIZE   = 4;
  localparam int REG_DECIM       = 5;

  // item codes
  localparam logic FN_LOAD    = 1'b0;
  localparam logic FN_ADVANCE = 1'b1;

endpackage

[sim/crk_checker.sv]
// ----------------------------------------------------------------------------
// crk_checker
// tracks register writes and input items, predicts each rk4 sample and
// compares it with the samples leaving the integrator
// ----------------------------------------------------------------------------
module crk_checker import crk_pkg::*; import crk_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_func,
  input  fx_t         in_init_x,
  input  fx_t         in_init_y,
  input  fx_t         in_init_z,
  input  logic        out_valid,
  input  logic        out_ready,
  input  fx_t         out_x,
  input  fx_t         out_y,
  input  fx_t         out_z,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  typedef logic signed [127:0] wide_t;
  typedef struct packed { fx_t x; fx_t y; fx_t z; } sample_t;

  fx_t         ca, cb, m0, m1, sx, sy, sz;
  logic [31:0] dt;
  logic [15:0] dec, cnt;
  sample_t     samples_due[$];

  function automatic fx_t sat(input wide_t v);
    if (v > wide_t'(FX_MAX)) return FX_MAX;
    if (v < wide_t'(FX_MIN)) return FX_MIN;
    return fx_t'(v);
  endfunction

  function automatic fx_t add_s(input fx_t a, input fx_t b);
    wide_t w;
    w = a;
    return sat(w + b);
  endfunction

  function automatic fx_t sub_s(input fx_t a, input fx_t b);
    wide_t w;
    w = a;
    return sat(w - b);
  endfunction

  function automatic fx_t abs_s(input fx_t a);
    return (a < 0) ? sub_s('0, a) : a;
  endfunction

  // floor(a*b / 2^sh), optionally then floor / 6
  function automatic fx_t mul_s(input fx_t a, input fx_t b, input int sh, input bit by6);
    wide_t p, q;
    p = a;
    p = p * b;
    p = p >>> sh;
    if (by6) begin
      q = p / 6;
      if (p % 6 != 0 && p < 0) q = q - 1;
      p = q;
    end
    return sat(p);
  endfunction

  task automatic chua_deriv(input fx_t x, input fx_t y, input fx_t z,
                            output fx_t dx, output fx_t dy, output fx_t dz);
    fx_t p, g;
    p  = sub_s(abs_s(add_s(x, FX_ONE)), abs_s(sub_s(x, FX_ONE)));
    g  = add_s(mul_s(m1, x, 32, 0), mul_s(sub_s(m0, m1), p, 32, 0));
    dx = mul_s(ca, sub_s(sub_s(y, x), g), 32, 0);
    dy = add_s(sub_s(x, y), z);
    dz = sub_s('0, mul_s(cb, y, 32, 0));
  endtask

  task automatic rk4_advance();
    fx_t s[3], k1[3], k2[3], k3[3], k4[3], t[3], h, sum;
    s = '{sx, sy, sz};
    h = fx_t'({16'd0, dt});
    chua_deriv(s[0], s[1], s[2], k1[0], k1[1], k1[2]);
    foreach (t[i]) t[i] = add_s(s[i], mul_s(k1[i], h, 33, 0));
    chua_deriv(t[0], t[1], t[2], k2[0], k2[1], k2[2]);
    foreach (t[i]) t[i] = add_s(s[i], mul_s(k2[i], h, 33, 0));
    chua_deriv(t[0], t[1], t[2], k3[0], k3[1], k3[2]);
    foreach (t[i]) t[i] = add_s(s[i], mul_s(k3[i], h, 32, 0));
    chua_deriv(t[0], t[1], t[2], k4[0], k4[1], k4[2]);
    foreach (s[i]) begin
      sum  = add_s(add_s(add_s(k1[i], add_s(k2[i], k2[i])), add_s(k3[i], k3[i])), k4[i]);
      s[i] = add_s(s[i], mul_s(sum, h, 32, 1));
    end
    sx = s[0];
    sy = s[1];
    sz = s[2];
  endtask

  task automatic field_check(input string nm, input fx_t want, input fx_t got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h got %h", nm, want, got);
    end
  endtask

  assign pending = samples_due.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      ca = '0; cb = '0; m0 = '0; m1 = '0;
      dt = 32'd429497; dec = 16'd100;
      sx = '0; sy = '0; sz = '0; cnt = '0;
      errors = 0;
    end else begin
      // samples leaving the block
      if (out_valid && out_ready) begin
        if (samples_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected sample %h %h %h", out_x, out_y, out_z);
        end else begin
          sample_t e;
          e = samples_due.pop_front();
          field_check("x", e.x, out_x);
          field_check("y", e.y, out_y);
          field_check("z", e.z, out_z);
        end
      end
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (int'(paddr >> 3))
          REG_COEF_A:      ca = pwdata[47:0];
          REG_COEF_B:      cb = pwdata[47:0];
          REG_SLOPE_INNER: m0 = pwdata[47:0];
          REG_SLOPE_OUTER: m1 = pwdata[47:0];
          REG_STEP_SIZE:   dt = pwdata[31:0];
          REG_DECIM:       dec = pwdata[15:0];
          default: ;
        endcase
      end
      // items entering the block
      if (in_valid && in_ready) begin
        if (in_func == FN_LOAD) begin
          sx = in_init_x; sy = in_init_y; sz = in_init_z; cnt = '0;
        end else begin
          rk4_advance();
          cnt = cnt + 16'd1;
          if (cnt >= dec) begin
            cnt = '0;
            samples_due.push_back('{sx, sy, sz});
          end
        end
      end
    end
  end

endmodule

[sim/chua_rk4_integrator_tb.sv]
// ----------------------------------------------------------------------------
// chua_rk4_integrator_tb
// drives load and advance items under several register settings with random
// gaps on both channels; a checker beside the block predicts every sample
// ----------------------------------------------------------------------------
module chua_rk4_integrator_tb;
  import crk_pkg::*;
  import crk_tb_pkg::*;

  localparam longint CYCLE_LIMIT = 10000000;
  // drain time that covers the last advance item
  localparam int     DRAIN_CYCLES = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = FN_LOAD;
  fx_t         in_init_x = '0;
  fx_t         in_init_y = '0;
  fx_t         in_init_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  fx_t         out_x, out_y, out_z;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          errors, pending;
  longint      cycles = 0;
  bit          calm = 1'b0;   // phases with no idling at all
  int          stall = 0;
  int          g;

  chua_rk4_integrator dut (.*);

  crk_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_init_x(in_init_x), .in_init_y(in_init_y), .in_init_z(in_init_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // safety net against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // gap length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall > 0) begin
      stall     <= stall - 1;
      out_ready <= 1'b0;
    end else begin
      g = idle_len();
      out_ready <= (g == 0);
      if (g != 0) stall <= g - 1;
    end
  end

  function automatic fx_t to_fx(input real r);
    return fx_t'(longint'(r * 4294967296.0));
  endfunction

  function automatic fx_t rand_fx();
    return fx_t'({$urandom, $urandom});
  endfunction

  // small state value, between -4 and +4
  function automatic fx_t near_fx();
    return to_fx((real'($urandom_range(0, 8000)) - 4000.0) / 1000.0);
  endfunction

  // one item; valid stays up across back-to-back items
  task automatic send_item(input logic fn, input fx_t x, input fx_t y, input fx_t z);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= fn;
    in_init_x <= x;
    in_init_y <= y;
    in_init_z <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic advance_item();
    send_item(FN_ADVANCE, rand_fx(), rand_fx(), rand_fx());
  endtask

  // wait until every sample is out and the last step has finished
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup then access cycle; the write lands on the access edge, then psel is
  // low again before the next transfer
  task automatic reg_write(input int idx, input logic [63:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 6'(idx * 8);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input fx_t a, input fx_t b, input fx_t mi, input fx_t mo,
                          input logic [31:0] h, input logic [15:0] d);
    reg_write(REG_COEF_A, 64'(a));
    reg_write(REG_COEF_B, 64'(b));
    reg_write(REG_SLOPE_INNER, 64'(mi));
    reg_write(REG_SLOPE_OUTER, 64'(mo));
    reg_write(REG_STEP_SIZE, 64'(h));
    reg_write(REG_DECIM, 64'(d));
  endtask

  // chua-like coefficients or fully random ones
  task automatic random_regs();
    logic [31:0] h;
    logic [15:0] d;
    h = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 1 << 27) : $urandom;
    d = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 4)) : 16'($urandom_range(5, 20));
    if ($urandom_range(0, 3) != 0)
      set_regs(to_fx(8.0 + real'($urandom_range(0, 8000)) / 1000.0),
               to_fx(10.0 + real'($urandom_range(0, 20000)) / 1000.0),
               to_fx(-1.5 + real'($urandom_range(0, 1000)) / 1000.0),
               to_fx(-1.0 + real'($urandom_range(0, 1000)) / 1000.0), h, d);
    else
      set_regs(rand_fx(), rand_fx(), rand_fx(), rand_fx(), h, d);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: a few steps from the zero state, decim 100 so no sample
    repeat (3) advance_item();
    settle();

    // textbook double scroll, every step emitted
    set_regs(to_fx(15.6), to_fx(28.0), to_fx(-1.143), to_fx(-0.714), 32'd42949673, 16'd1);
    send_item(FN_LOAD, to_fx(0.7), '0, '0);
    repeat (4) advance_item();
    // kinks of the nonlinearity at plus and minus one
    send_item(FN_LOAD, FX_ONE, -FX_ONE, FX_ONE);
    repeat (2) advance_item();
    send_item(FN_LOAD, -FX_ONE, FX_ONE, '0);
    repeat (2) advance_item();
    // state at the rails, saturation everywhere
    send_item(FN_LOAD, FX_MAX, FX_MIN, FX_MAX);
    repeat (2) advance_item();
    send_item(FN_LOAD, FX_MIN, FX_MAX, FX_MIN);
    repeat (2) advance_item();
    settle();

    // extreme registers, largest step
    set_regs(FX_MAX, FX_MIN, FX_MIN, FX_MAX, 32'hFFFF_FFFF, 16'd1);
    send_item(FN_LOAD, FX_MAX, FX_MAX, FX_MIN);
    repeat (3) advance_item();
    send_item(FN_LOAD, '0, '0, '0);
    advance_item();
    settle();
    set_regs(FX_MIN, FX_MAX, FX_MAX, FX_MIN, 32'd0, 16'd2);
    send_item(FN_LOAD, FX_MIN, FX_MAX, FX_MAX);
    repeat (4) advance_item();
    settle();

    // largest decimation: steps count but nothing comes out
    set_regs(to_fx(9.0), to_fx(14.0), to_fx(-1.2), to_fx(-0.6), 32'd4294967, 16'hFFFF);
    send_item(FN_LOAD, near_fx(), near_fx(), near_fx());
    repeat (3) advance_item();
    settle();

    // random phases: mostly advancing trajectories, occasional reloads
    for (int ph = 0; ph < 9; ph++) begin
      random_regs();
      calm = (ph % 4 == 1);
      send_item(FN_LOAD, near_fx(), near_fx(), near_fx());
      for (int n = 0; n < 190; n++) begin
        if ($urandom_range(0, 99) < 94)
          advance_item();
        else if ($urandom_range(0, 1) != 0)
          send_item(FN_LOAD, near_fx(), near_fx(), near_fx());
        else
          send_item(FN_LOAD, rand_fx(), rand_fx(), rand_fx());
      end
      settle();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
